>>> sv/cco_pkg.sv
package cco_pkg;

   localparam logic [1:0] MODE_CIRCLE       = 2'd0;
   localparam logic [1:0] MODE_CAPSULE      = 2'd1;
   localparam logic [1:0] MODE_CAPSULE_PAIR = 2'd2;

   localparam int LANES = 4;

endpackage

>>> sv/cco_lane.sv
// one capsule against circle test, fully pipelined
module cco_lane #(
   parameter int CW = 16
) (
   input  logic              clock,
   input  logic              en,
   input  logic signed [CW-1:0] sx,
   input  logic signed [CW-1:0] sy,
   input  logic signed [CW-1:0] ex,
   input  logic signed [CW-1:0] ey,
   input  logic        [CW-2:0] rc,
   input  logic signed [CW-1:0] px,
   input  logic signed [CW-1:0] py,
   input  logic        [CW-2:0] rp,
   input  logic              circle,
   output logic              hit
);
   localparam int DW = CW + 1;        // differences
   localparam int PW = 2 * DW + 1;    // dot products
   localparam int NW = PW + DW + 1;   // numerator
   localparam int QW = DW + 1;        // quotient bits

   // nearest point select
   localparam logic [1:0] SEL_START = 2'd0;
   localparam logic [1:0] SEL_END   = 2'd1;
   localparam logic [1:0] SEL_PROJ  = 2'd2;

   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [PW-1:0] dot_type;

   // stage 1: differences
   diff_type lx_ff, ly_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [CW-1:0] sx_ff, sy_ff, ex_ff, ey_ff, px_ff, py_ff;
   logic [CW-2:0] rc_ff, rp_ff;
   logic circ1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff <= circle ? '0 : DW'(ex) - DW'(sx);
         ly_ff <= circle ? '0 : DW'(ey) - DW'(sy);
         ax_ff <= DW'(px) - DW'(sx);
         ay_ff <= DW'(py) - DW'(sy);
         bx_ff <= DW'(px) - DW'(ex);
         by_ff <= DW'(py) - DW'(ey);
         sx_ff <= sx; sy_ff <= sy; ex_ff <= ex; ey_ff <= ey;
         px_ff <= px; py_ff <= py; rc_ff <= rc; rp_ff <= rp;
         circ1_ff <= circle;
      end
   end

   // stage 2: products
   logic signed [2*DW-1:0] m1x_ff, m1y_ff, m2x_ff, m2y_ff, m3x_ff, m3y_ff;
   diff_type lx2_ff, ly2_ff;
   logic signed [CW-1:0] sx2_ff, sy2_ff, ex2_ff, ey2_ff, px2_ff, py2_ff;
   logic [CW-2:0] rc2_ff, rp2_ff;
   logic circ2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m1x_ff <= lx_ff * ax_ff; m1y_ff <= ly_ff * ay_ff;
         m2x_ff <= lx_ff * bx_ff; m2y_ff <= ly_ff * by_ff;
         m3x_ff <= lx_ff * lx_ff; m3y_ff <= ly_ff * ly_ff;
         lx2_ff <= lx_ff; ly2_ff <= ly_ff;
         sx2_ff <= sx_ff; sy2_ff <= sy_ff; ex2_ff <= ex_ff; ey2_ff <= ey_ff;
         px2_ff <= px_ff; py2_ff <= py_ff; rc2_ff <= rc_ff; rp2_ff <= rp_ff;
         circ2_ff <= circ1_ff;
      end
   end

   // stage 3: dot sums and clamp decision
   dot_type d1, d2, l2;
   always_comb begin
      d1 = PW'(m1x_ff) + PW'(m1y_ff);
      d2 = PW'(m2x_ff) + PW'(m2y_ff);
      l2 = PW'(m3x_ff) + PW'(m3y_ff);
   end

   logic [1:0] sel3_ff;
   dot_type d1_ff, l2_ff;
   diff_type lx3_ff, ly3_ff;
   logic signed [CW-1:0] sx3_ff, sy3_ff, ex3_ff, ey3_ff, px3_ff, py3_ff;
   logic [CW-2:0] rc3_ff, rp3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         if (circ2_ff || d1 < 0 || l2 == 0) sel3_ff <= SEL_START;
         else if (d2 > 0)                  sel3_ff <= SEL_END;
         else                              sel3_ff <= SEL_PROJ;
         d1_ff <= d1; l2_ff <= l2;
         lx3_ff <= lx2_ff; ly3_ff <= ly2_ff;
         sx3_ff <= sx2_ff; sy3_ff <= sy2_ff; ex3_ff <= ex2_ff; ey3_ff <= ey2_ff;
         px3_ff <= px2_ff; py3_ff <= py2_ff; rc3_ff <= rc2_ff; rp3_ff <= rp2_ff;
      end
   end

   // divider: one quotient bit per stage, both axes side by side
   // quotient < 2^QW, so the shifted divisor starts at den << (QW-1)
   localparam int RW = NW + 1;
   logic [RW-1:0] rx_ff [QW+1];
   logic [RW-1:0] ry_ff [QW+1];
   logic [QW-1:0] qx_ff [QW+1];
   logic [QW-1:0] qy_ff [QW+1];
   logic [PW:0]   dv_ff [QW+1];
   logic [1:0]    sl_ff [QW+1];
   logic          ngx_ff [QW+1];
   logic          ngy_ff [QW+1];
   logic signed [CW-1:0] s_x_ff [QW+1];
   logic signed [CW-1:0] s_y_ff [QW+1];
   logic signed [CW-1:0] e_x_ff [QW+1];
   logic signed [CW-1:0] e_y_ff [QW+1];
   logic signed [CW-1:0] p_x_ff [QW+1];
   logic signed [CW-1:0] p_y_ff [QW+1];
   logic [CW-2:0] r_c_ff [QW+1];
   logic [CW-2:0] r_p_ff [QW+1];

   // stage 4: numerators 2*d*|l| + len2, one multiply per axis
   logic [DW-1:0] mlx, mly;
   always_comb begin
      mlx = lx3_ff[DW-1] ? DW'(-lx3_ff) : DW'(lx3_ff);
      mly = ly3_ff[DW-1] ? DW'(-ly3_ff) : DW'(ly3_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0] <= RW'(NW'({(NW-PW)'(0), d1_ff} * {(NW-DW)'(0), mlx}) * NW'(2)
                         + NW'(l2_ff));
         ry_ff[0] <= RW'(NW'({(NW-PW)'(0), d1_ff} * {(NW-DW)'(0), mly}) * NW'(2)
                         + NW'(l2_ff));
         qx_ff[0] <= '0; qy_ff[0] <= '0;
         dv_ff[0] <= {l2_ff, 1'b0};
         ngx_ff[0] <= lx3_ff[DW-1]; ngy_ff[0] <= ly3_ff[DW-1];
         sl_ff[0] <= sel3_ff;
         s_x_ff[0] <= sx3_ff; s_y_ff[0] <= sy3_ff;
         e_x_ff[0] <= ex3_ff; e_y_ff[0] <= ey3_ff;
         p_x_ff[0] <= px3_ff; p_y_ff[0] <= py3_ff;
         r_c_ff[0] <= rc3_ff; r_p_ff[0] <= rp3_ff;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int SH = QW - 1 - k;
      logic [RW+QW-1:0] dsh;
      assign dsh = (RW+QW)'(dv_ff[k]) << SH;
      always_ff @(posedge clock) begin
         if (en) begin
            if ((RW+QW)'(rx_ff[k]) >= dsh) begin
               rx_ff[k+1] <= rx_ff[k] - RW'(dsh);
               qx_ff[k+1] <= qx_ff[k] | (QW'(1) << SH);
            end else begin
               rx_ff[k+1] <= rx_ff[k];
               qx_ff[k+1] <= qx_ff[k];
            end
            if ((RW+QW)'(ry_ff[k]) >= dsh) begin
               ry_ff[k+1] <= ry_ff[k] - RW'(dsh);
               qy_ff[k+1] <= qy_ff[k] | (QW'(1) << SH);
            end else begin
               ry_ff[k+1] <= ry_ff[k];
               qy_ff[k+1] <= qy_ff[k];
            end
            dv_ff[k+1] <= dv_ff[k]; sl_ff[k+1] <= sl_ff[k];
            ngx_ff[k+1] <= ngx_ff[k]; ngy_ff[k+1] <= ngy_ff[k];
            s_x_ff[k+1] <= s_x_ff[k]; s_y_ff[k+1] <= s_y_ff[k];
            e_x_ff[k+1] <= e_x_ff[k]; e_y_ff[k+1] <= e_y_ff[k];
            p_x_ff[k+1] <= p_x_ff[k]; p_y_ff[k+1] <= p_y_ff[k];
            r_c_ff[k+1] <= r_c_ff[k]; r_p_ff[k+1] <= r_p_ff[k];
         end
      end
   end

   // nearest point and differences to the centre
   logic signed [DW:0] nx, ny;
   always_comb begin
      case (sl_ff[QW])
         SEL_END: begin
            nx = (DW+1)'(e_x_ff[QW]);
            ny = (DW+1)'(e_y_ff[QW]);
         end
         SEL_PROJ: begin
            nx = ngx_ff[QW] ? (DW+1)'(s_x_ff[QW]) - (DW+1)'(qx_ff[QW])
                            : (DW+1)'(s_x_ff[QW]) + (DW+1)'(qx_ff[QW]);
            ny = ngy_ff[QW] ? (DW+1)'(s_y_ff[QW]) - (DW+1)'(qy_ff[QW])
                            : (DW+1)'(s_y_ff[QW]) + (DW+1)'(qy_ff[QW]);
         end
         default: begin
            nx = (DW+1)'(s_x_ff[QW]);
            ny = (DW+1)'(s_y_ff[QW]);
         end
      endcase
   end

   diff_type ddx_ff, ddy_ff;
   logic [CW-1:0] rs_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ddx_ff <= DW'(nx - (DW+1)'(p_x_ff[QW]));
         ddy_ff <= DW'(ny - (DW+1)'(p_y_ff[QW]));
         rs_ff  <= CW'(r_c_ff[QW]) + CW'(r_p_ff[QW]);
      end
   end

   logic [2*DW-1:0] sqx_ff, sqy_ff;
   logic [2*CW-1:0] rr_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= (2*DW)'(ddx_ff * ddx_ff);
         sqy_ff <= (2*DW)'(ddy_ff * ddy_ff);
         rr_ff  <= rs_ff * rs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) hit <= ((2*DW+1)'(sqx_ff) + (2*DW+1)'(sqy_ff)) < (2*DW+1)'(rr_ff);
   end
endmodule

>>> sv/capsule_circle_overlap_test.sv
// one beat per cycle sustained while rsp is not stalled
// the pipeline depth is set by the quotient divider, one bit per stage
// reset clears the stage valid bits only; the pipeline holds on a stalled rsp
module capsule_circle_overlap_test #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_mode,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_y,
   input  logic [COORD_WIDTH-2:0] req_first_radius,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_y,
   input  logic [COORD_WIDTH-2:0] req_second_radius,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit
);
   localparam int LAT = COORD_WIDTH + 9;
   localparam int NL = cco_pkg::LANES;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic [1:0] mode_ff [LAT];
   logic [NL-1:0] lane_hit;

   // the whole pipe moves when the output stage is free or drains
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff[0] <= req_mode;
         for (int i = 1; i < LAT; i++) mode_ff[i] <= mode_ff[i-1];
      end
   end

   logic is_circ;
   assign is_circ = req_mode == cco_pkg::MODE_CIRCLE;

   // lanes 0/1: first capsule against second start/end; lanes 2/3 reversed
   cco_lane #(.CW(COORD_WIDTH)) u_lane0 (
      .clock, .en,
      .sx(req_first_start_x), .sy(req_first_start_y),
      .ex(req_first_end_x), .ey(req_first_end_y), .rc(req_first_radius),
      .px(req_second_start_x), .py(req_second_start_y), .rp(req_second_radius),
      .circle(is_circ), .hit(lane_hit[0]));
   cco_lane #(.CW(COORD_WIDTH)) u_lane1 (
      .clock, .en,
      .sx(req_first_start_x), .sy(req_first_start_y),
      .ex(req_first_end_x), .ey(req_first_end_y), .rc(req_first_radius),
      .px(req_second_end_x), .py(req_second_end_y), .rp(req_second_radius),
      .circle(1'b0), .hit(lane_hit[1]));
   cco_lane #(.CW(COORD_WIDTH)) u_lane2 (
      .clock, .en,
      .sx(req_second_start_x), .sy(req_second_start_y),
      .ex(req_second_end_x), .ey(req_second_end_y), .rc(req_second_radius),
      .px(req_first_start_x), .py(req_first_start_y), .rp(req_first_radius),
      .circle(1'b0), .hit(lane_hit[2]));
   cco_lane #(.CW(COORD_WIDTH)) u_lane3 (
      .clock, .en,
      .sx(req_second_start_x), .sy(req_second_start_y),
      .ex(req_second_end_x), .ey(req_second_end_y), .rc(req_second_radius),
      .px(req_first_end_x), .py(req_first_end_y), .rp(req_first_radius),
      .circle(1'b0), .hit(lane_hit[3]));

   logic hit_in;
   always_comb begin
      case (mode_ff[LAT-1])
         cco_pkg::MODE_CIRCLE, cco_pkg::MODE_CAPSULE: hit_in = lane_hit[0];
         cco_pkg::MODE_CAPSULE_PAIR: hit_in = |lane_hit;
         default: hit_in = 1'b0;
      endcase
   end

   logic rsp_valid_ff, rsp_hit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) rsp_hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
endmodule

>>> bench/tb_capsule_circle_overlap_test.sv
`timescale 1ns / 100ps

module tb_capsule_circle_overlap_test;

   localparam int CW = 16;
   localparam int LATENCY = CW + 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [CW-2:0] radius_type;

   typedef struct packed {
      logic [1:0] mode;
      coord_type ax, ay, bx, by;
      radius_type ra;
      coord_type cx, cy, dx, dy;
      radius_type rb;
   } shape_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   coord_type req_first_start_x = '0, req_first_start_y = '0;
   coord_type req_first_end_x = '0, req_first_end_y = '0;
   radius_type req_first_radius = '0;
   coord_type req_second_start_x = '0, req_second_start_y = '0;
   coord_type req_second_end_x = '0, req_second_end_y = '0;
   radius_type req_second_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;

   logic expected_hits[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit idling_on = 1'b1;

   always #2 clock = ~clock;

   capsule_circle_overlap_test #(.COORD_WIDTH(CW)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_first_start_x(req_first_start_x), .req_first_start_y(req_first_start_y),
      .req_first_end_x(req_first_end_x), .req_first_end_y(req_first_end_y),
      .req_first_radius(req_first_radius),
      .req_second_start_x(req_second_start_x), .req_second_start_y(req_second_start_y),
      .req_second_end_x(req_second_end_x), .req_second_end_y(req_second_end_y),
      .req_second_radius(req_second_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit)
   );

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // exact circle test on integer units
   function automatic logic circles_overlap(longint px, longint py, longint qx,
                                            longint qy, longint r1, longint r2);
      longint dx, dy;
      logic [127:0] dist2, rsum2;
      dx = px - qx;
      dy = py - qy;
      dist2 = 128'(dx * dx) + 128'(dy * dy);
      rsum2 = 128'((r1 + r2) * (r1 + r2));
      return dist2 < rsum2;
   endfunction

   // offset lx*d/len2 rounded half away from zero, sign taken from lx
   function automatic longint rounded_offset(longint lx, longint d, longint len2);
      logic [127:0] num, q;
      longint mag;
      mag = lx < 0 ? -lx : lx;
      num = 128'(d) * 128'(mag) * 2 + 128'(len2);
      q = num / (128'(len2) * 2);
      return lx < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic segment_circle_overlap(longint sx, longint sy, longint ex,
                                                   longint ey, longint rc, longint px,
                                                   longint py, longint rp);
      longint lx, ly, d1, d2, len2, nx, ny;
      lx = ex - sx;
      ly = ey - sy;
      d1 = lx * (px - sx) + ly * (py - sy);
      d2 = lx * (px - ex) + ly * (py - ey);
      len2 = lx * lx + ly * ly;
      if (d1 < 0) begin
         nx = sx; ny = sy;
      end else if (d2 > 0) begin
         nx = ex; ny = ey;
      end else if (len2 == 0) begin
         nx = sx; ny = sy;
      end else begin
         nx = sx + rounded_offset(lx, d1, len2);
         ny = sy + rounded_offset(ly, d1, len2);
      end
      return circles_overlap(nx, ny, px, py, rc, rp);
   endfunction

   function automatic logic predict_overlap(shape_pair_type p);
      case (p.mode)
         cco_pkg::MODE_CIRCLE: begin
            return circles_overlap(p.ax, p.ay, p.cx, p.cy, p.ra, p.rb);
         end
         cco_pkg::MODE_CAPSULE: begin
            return segment_circle_overlap(p.ax, p.ay, p.bx, p.by, p.ra,
                                          p.cx, p.cy, p.rb);
         end
         cco_pkg::MODE_CAPSULE_PAIR: begin
            return segment_circle_overlap(p.ax, p.ay, p.bx, p.by, p.ra, p.cx, p.cy, p.rb)
                || segment_circle_overlap(p.ax, p.ay, p.bx, p.by, p.ra, p.dx, p.dy, p.rb)
                || segment_circle_overlap(p.cx, p.cy, p.dx, p.dy, p.rb, p.ax, p.ay, p.ra)
                || segment_circle_overlap(p.cx, p.cy, p.dx, p.dy, p.rb, p.bx, p.by, p.ra);
         end
         default: return 1'b0;
      endcase
   endfunction

   // valid stays high between back to back beats; it drops only for a gap
   task automatic send_pair(input shape_pair_type p);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= p.mode;
      req_first_start_x <= p.ax;
      req_first_start_y <= p.ay;
      req_first_end_x <= p.bx;
      req_first_end_y <= p.by;
      req_first_radius <= p.ra;
      req_second_start_x <= p.cx;
      req_second_start_y <= p.cy;
      req_second_end_x <= p.dx;
      req_second_end_y <= p.dy;
      req_second_radius <= p.rb;
      do @(posedge clock); while (!req_ready);
      expected_hits.push_back(predict_overlap(p));
   endtask

   // rsp side backpressure in bursts
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            logic want;
            want = expected_hits.pop_front();
            if (rsp_hit !== want)
               report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** capsule_circle_overlap_test: FAILED **");
         $finish;
      end
   end

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic shape_pair_type rand_pair(logic [1:0] mode);
      shape_pair_type p;
      int span, rspan;
      span = $urandom_range(0, 3) == 0 ? 0 : 2000;
      rspan = $urandom_range(0, 3) == 0 ? 32767 : 600;
      p.mode = mode;
      p.ax = rand_coord(span);
      p.ay = rand_coord(span);
      p.bx = rand_coord(span);
      p.by = rand_coord(span);
      p.cx = rand_coord(span);
      p.cy = rand_coord(span);
      p.dx = rand_coord(span);
      p.dy = rand_coord(span);
      p.ra = radius_type'($urandom_range(0, rspan));
      p.rb = radius_type'($urandom_range(0, rspan));
      // zero-length segments now and then
      if ($urandom_range(0, 9) == 0) begin
         p.bx = p.ax; p.by = p.ay;
      end
      if ($urandom_range(0, 9) == 0) begin
         p.dx = p.cx; p.dy = p.cy;
      end
      return p;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
   endtask

   task automatic test_circle_extremes();
      shape_pair_type p;
      p = '0;
      p.mode = cco_pkg::MODE_CIRCLE;
      send_pair(p);
      p.ax = 16'sh7fff; p.ay = 16'sh7fff; p.cx = 16'sh8000; p.cy = 16'sh8000;
      p.ra = '1; p.rb = '1;
      send_pair(p);
      p.ra = 15'd0; p.rb = 15'd0;
      send_pair(p);
      // touching circles do not hit
      p = '0; p.mode = cco_pkg::MODE_CIRCLE; p.cx = 16'sd30; p.ra = 15'd10; p.rb = 15'd20;
      send_pair(p);
      p.rb = 15'd21;
      send_pair(p);
   endtask

   task automatic test_capsule_cases();
      shape_pair_type p;
      p = '0;
      p.mode = cco_pkg::MODE_CAPSULE;
      p.ax = -16'sd100; p.bx = 16'sd100; p.cy = 16'sd50; p.ra = 15'd25; p.rb = 15'd26;
      send_pair(p);
      p.cx = -16'sd300;
      send_pair(p);
      p.cx = 16'sd300;
      send_pair(p);
      // zero-length segment
      p.bx = p.ax; p.cx = -16'sd100;
      send_pair(p);
      p.ax = 16'sh8000; p.ay = 16'sh8000; p.bx = 16'sh7fff; p.by = 16'sh7fff;
      p.cx = 16'sh7fff; p.cy = 16'sh8000; p.ra = '1; p.rb = '1;
      send_pair(p);
      p.ra = 15'd0; p.rb = 15'd0; p.cx = 16'sd3; p.cy = -16'sd7;
      send_pair(p);
   endtask

   task automatic test_capsule_pair_and_unused();
      shape_pair_type p;
      p = '0;
      p.mode = cco_pkg::MODE_CAPSULE_PAIR;
      p.ax = -16'sd100; p.bx = 16'sd100; p.cy = 16'sd40; p.dy = 16'sd200;
      p.ra = 15'd20; p.rb = 15'd25;
      send_pair(p);
      // crossing segments without endpoint contact miss in this scheme
      p.cx = 16'sd0; p.cy = -16'sd200; p.dx = 16'sd0; p.dy = 16'sd200;
      p.ra = 15'd1; p.rb = 15'd1;
      send_pair(p);
      p.ax = 16'sh8000; p.ay = 16'sh7fff; p.bx = 16'sh7fff; p.by = 16'sh8000;
      p.cx = 16'sh8000; p.cy = 16'sh8000; p.dx = 16'sh7fff; p.dy = 16'sh7fff;
      p.ra = '1; p.rb = '1;
      send_pair(p);
      p.mode = MODE_UNUSED;
      send_pair(p);
      p = '0; p.mode = MODE_UNUSED;
      send_pair(p);
   endtask

   task automatic test_random_mix(input int count);
      shape_pair_type p;
      for (int i = 0; i < count; i++) begin
         p = rand_pair($urandom_range(0, 9) == 0 ? MODE_UNUSED : 2'($urandom_range(0, 2)));
         send_pair(p);
      end
   endtask

   task automatic test_drain_pause();
      wait_drained();
      test_random_mix(50);
   endtask

   task automatic test_full_rate(input int count);
      idling_on = 1'b0;
      test_random_mix(count);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_circle_extremes();
      test_capsule_cases();
      test_capsule_pair_and_unused();
      test_random_mix(700);
      test_drain_pause();
      test_full_rate(380);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("** capsule_circle_overlap_test: PASSED **");
      end else begin
         $display("** capsule_circle_overlap_test: FAILED **");
      end
      $finish;
   end

endmodule
